FILE: rtl/assert_macros.svh
// Assertion macros used by the deframer RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define KFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define KFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/kfd_pkg.sv
// Package for the KISS frame deframer: codes, sizes, state and result types.
// Used by kfd_step and kiss_frame_deframer; depends on nothing.
package kfd_pkg;

    localparam int BUF_LEN = 512;
    localparam int CNT_W   = $clog2(BUF_LEN);
    localparam int IDX_W   = 9;
    localparam int IDLE_W  = 16;

    localparam logic [CNT_W-1:0]  OVF_LIMIT     = CNT_W'(BUF_LEN - 2);
    localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [IDLE_W-1:0] IDLE_MAX      = 16'hFFFF;

    localparam logic [7:0] FEND_CODE  = 8'hC0;
    localparam logic [7:0] FESC_CODE  = 8'hDB;
    localparam logic [7:0] TFEND_CODE = 8'hDC;
    localparam logic [7:0] TFESC_CODE = 8'hDD;
    localparam logic [7:0] RETURN_CODE = 8'hFF;

    localparam logic [3:0] CMD_DATA  = 4'h0;
    localparam logic [3:0] CMD_CFG_B = 4'hB;
    localparam logic [3:0] CMD_CFG_C = 4'hC;
    localparam logic [3:0] CMD_CFG_D = 4'hD;
    localparam logic [3:0] CMD_CFG_F = 4'hF;

    typedef enum logic {
        ITEM_BYTE = 1'b0,
        ITEM_TICK = 1'b1
    } t_item_kind;

    typedef enum logic {
        EVT_BYTE      = 1'b0,
        EVT_FRAME_END = 1'b1
    } t_event_kind;

    typedef enum logic [2:0] {
        CLS_ABORTED     = 3'd0,
        CLS_RETURN      = 3'd1,
        CLS_SHORT       = 3'd2,
        CLS_OTHER_PORT  = 3'd3,
        CLS_DATA        = 3'd4,
        CLS_CONFIG      = 3'd5,
        CLS_UNSUPPORTED = 3'd6
    } t_frame_class;

    typedef struct packed {
        logic              esc;
        logic [CNT_W-1:0]  count;
        logic [IDLE_W-1:0] idle;
        logic [7:0]        first;
    } t_kfd_state;

    typedef struct packed {
        t_event_kind      kind;
        logic             restarted;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic [IDX_W-1:0] frame_length;
        t_frame_class     frame_class;
        logic [3:0]       kiss_command;
        logic [3:0]       kiss_port;
    } t_kfd_result;

endpackage

FILE: rtl/kfd_step.sv
// Per-item decode of the KISS deframer: next state and the result for one item.
// Purely combinational; depends on kfd_pkg.
module kfd_step (
    input  kfd_pkg::t_kfd_state         i_state,
    input  logic [kfd_pkg::IDLE_W-1:0]  i_timeout,
    input  logic                        i_is_tick,
    input  logic [7:0]                  i_rx_byte,
    output kfd_pkg::t_kfd_state         o_state,
    output kfd_pkg::t_kfd_result        o_result,
    output logic                        o_result_valid
);

    logic                        restart;
    logic [kfd_pkg::CNT_W-1:0]   count0;
    logic [7:0]                  unesc;
    logic [3:0]                  cmd_nib;
    logic [3:0]                  port_nib;
    kfd_pkg::t_frame_class       cls;

    assign restart = ((i_state.count != '0) && (i_state.idle > i_timeout))
                     || (i_state.count >= kfd_pkg::OVF_LIMIT);
    assign count0  = restart ? '0 : i_state.count;
    assign cmd_nib  = i_state.first[3:0];
    assign port_nib = i_state.first[7:4];

    always_comb begin
        unesc = i_rx_byte;
        if (i_state.esc) begin
            if (i_rx_byte == kfd_pkg::TFESC_CODE) begin
                unesc = kfd_pkg::FESC_CODE;
            end else if (i_rx_byte == kfd_pkg::TFEND_CODE) begin
                unesc = kfd_pkg::FEND_CODE;
            end
        end
    end

    always_comb begin
        if (i_state.esc) begin
            cls = kfd_pkg::CLS_ABORTED;
        end else if (count0 == kfd_pkg::CNT_W'(1) && i_state.first == kfd_pkg::RETURN_CODE) begin
            cls = kfd_pkg::CLS_RETURN;
        end else if (count0 < kfd_pkg::CNT_W'(2)) begin
            cls = kfd_pkg::CLS_SHORT;
        end else if (port_nib != 4'h0) begin
            cls = kfd_pkg::CLS_OTHER_PORT;
        end else if (cmd_nib == kfd_pkg::CMD_DATA) begin
            cls = kfd_pkg::CLS_DATA;
        end else if (cmd_nib inside {kfd_pkg::CMD_CFG_B, kfd_pkg::CMD_CFG_C,
                                     kfd_pkg::CMD_CFG_D, kfd_pkg::CMD_CFG_F}) begin
            cls = kfd_pkg::CLS_CONFIG;
        end else begin
            cls = kfd_pkg::CLS_UNSUPPORTED;
        end
    end

    always_comb begin
        o_state        = i_state;
        o_result       = '0;
        o_result_valid = 1'b0;
        if (i_is_tick) begin
            if (i_state.idle != kfd_pkg::IDLE_MAX) begin
                o_state.idle = i_state.idle + 1'b1;
            end
        end else begin
            o_result.restarted = restart;
            o_state.count      = count0;
            if (i_rx_byte == kfd_pkg::FEND_CODE) begin
                o_state.count  = '0;
                o_state.esc    = 1'b0;
                o_result_valid = (count0 != '0);
                o_result.kind         = kfd_pkg::EVT_FRAME_END;
                o_result.frame_length = kfd_pkg::IDX_W'(count0);
                o_result.frame_class  = cls;
                o_result.kiss_command = cmd_nib;
                o_result.kiss_port    = port_nib;
            end else if (i_rx_byte == kfd_pkg::FESC_CODE) begin
                o_state.esc = 1'b1;
            end else begin
                o_state.esc   = 1'b0;
                o_state.count = count0 + 1'b1;
                o_state.idle  = '0;
                if (count0 == '0) begin
                    o_state.first = unesc;
                end
                o_result_valid      = 1'b1;
                o_result.kind       = kfd_pkg::EVT_BYTE;
                o_result.data_byte  = unesc;
                o_result.byte_index = kfd_pkg::IDX_W'(count0);
            end
        end
    end

endmodule

FILE: rtl/kiss_frame_deframer.sv
// KISS frame deframer top level: handshakes, state and result registers.
// A result appears on the master side in the cycle after its input transfer.
// One item per cycle when not stalled; the single result register refills as it drains.
// Reset (i_rst_n low, synchronous) clears the frame state and the output valid,
// and loads the idle timeout with 2000 ticks.
// Depends on kfd_pkg, kfd_step and assert_macros.svh.
`include "assert_macros.svh"

module kiss_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // restarted, decoded_byte, byte_index, frame_length, frame_class,
    // kiss_command, kiss_port, then two zero bits
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tuser    // event_kind
);

    kfd_pkg::t_kfd_state         r_state;
    kfd_pkg::t_kfd_state         n_state;
    kfd_pkg::t_kfd_result        r_result;
    kfd_pkg::t_kfd_result        n_result;
    logic                        n_result_valid;
    logic                        r_out_valid;
    logic [kfd_pkg::IDLE_W-1:0]  r_timeout;
    logic                        s_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    kfd_step u_step (
        .i_state        (r_state),
        .i_timeout      (r_timeout),
        .i_is_tick      (s_axis_tuser == kfd_pkg::ITEM_TICK),
        .i_rx_byte      (s_axis_tdata),
        .o_state        (n_state),
        .o_result       (n_result),
        .o_result_valid (n_result_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= kfd_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_state     <= n_state;
            r_out_valid <= n_result_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.kind;
    assign m_axis_tdata  = {2'b00,
                            r_result.kiss_port,
                            r_result.kiss_command,
                            r_result.frame_class,
                            r_result.frame_length,
                            r_result.byte_index,
                            r_result.data_byte,
                            r_result.restarted};

    `KFD_ASSERT(a_count_bound, r_state.count <= kfd_pkg::OVF_LIMIT, "frame count beyond limit")
    `KFD_ASSERT(a_idle_cleared, (s_fire && s_axis_tuser == kfd_pkg::ITEM_BYTE && s_axis_tdata != kfd_pkg::FEND_CODE && s_axis_tdata != kfd_pkg::FESC_CODE) |=> (r_state.idle == '0 && r_state.count != '0), "stored byte did not clear idle count")
    `KFD_ASSERT(a_end_nonempty, (m_axis_tvalid && m_axis_tuser == kfd_pkg::EVT_FRAME_END) |-> (r_result.frame_length != '0), "empty frame reported")
    `KFD_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (!r_state.esc && r_state.count == '0 && !r_out_valid), "state not cleared by reset")

endmodule

FILE: dv/kiss_frame_deframer_test.sv
// Self-checking testbench for kiss_frame_deframer: byte and tick stimulus with a
// cycle-free predictor, random stalls on both stream sides and a result scoreboard.
// Depends on kfd_pkg and the kiss_frame_deframer RTL.
`timescale 1ns / 100ps

module kiss_frame_deframer_test;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // rx_byte
    logic        s_axis_tuser = 1'b0;   // command
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;          // restarted, decoded_byte, byte_index, frame_length,
                                        // frame_class, kiss_command, kiss_port, two zero bits
    wire         m_axis_tuser;          // event_kind

    // Deframer state as the predictor sees it.
    logic                       esc_armed = 1'b0;
    int unsigned                frame_len = 0;
    logic [kfd_pkg::IDLE_W-1:0] idle_count = '0;
    logic [7:0]                 lead_byte = '0;
    logic [kfd_pkg::IDLE_W-1:0] idle_limit = kfd_pkg::TIMEOUT_RESET;

    kfd_pkg::t_kfd_result expected_events[$];
    int                   error_count = 0;
    int                   items_sent = 0;
    bit                   steady = 1'b0;

    kiss_frame_deframer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("[kiss_frame_deframer] ERROR");
        $finish;
    end

    function automatic void deframe_predict(input kfd_pkg::t_item_kind kind,
                                            input logic [7:0] value);
        kfd_pkg::t_kfd_result ev;
        logic                 restart;
        logic [7:0]           c;
        ev = '0;
        restart = 1'b0;
        c = value;
        if (kind == kfd_pkg::ITEM_TICK) begin
            if (idle_count != kfd_pkg::IDLE_MAX) idle_count++;
            return;
        end
        if (frame_len != 0 && idle_count > idle_limit) begin
            frame_len = 0;
            restart = 1'b1;
        end
        if (frame_len >= kfd_pkg::BUF_LEN - 2) begin
            frame_len = 0;
            restart = 1'b1;
        end
        ev.restarted = restart;
        if (c == kfd_pkg::FEND_CODE) begin
            if (frame_len != 0) begin
                ev.kind = kfd_pkg::EVT_FRAME_END;
                ev.frame_length = kfd_pkg::IDX_W'(frame_len);
                ev.kiss_command = lead_byte[3:0];
                ev.kiss_port = lead_byte[7:4];
                if (esc_armed) ev.frame_class = kfd_pkg::CLS_ABORTED;
                else if (frame_len == 1 && lead_byte == kfd_pkg::RETURN_CODE)
                    ev.frame_class = kfd_pkg::CLS_RETURN;
                else if (frame_len < 2) ev.frame_class = kfd_pkg::CLS_SHORT;
                else if (lead_byte[7:4] != 4'h0) ev.frame_class = kfd_pkg::CLS_OTHER_PORT;
                else if (lead_byte[3:0] == kfd_pkg::CMD_DATA)
                    ev.frame_class = kfd_pkg::CLS_DATA;
                else if (lead_byte[3:0] inside {kfd_pkg::CMD_CFG_B, kfd_pkg::CMD_CFG_C,
                                                kfd_pkg::CMD_CFG_D, kfd_pkg::CMD_CFG_F})
                    ev.frame_class = kfd_pkg::CLS_CONFIG;
                else ev.frame_class = kfd_pkg::CLS_UNSUPPORTED;
                expected_events.push_back(ev);
            end
            frame_len = 0;
            esc_armed = 1'b0;
            return;
        end
        if (c == kfd_pkg::FESC_CODE) begin
            esc_armed = 1'b1;
            return;
        end
        if (esc_armed) begin
            if (c == kfd_pkg::TFESC_CODE) c = kfd_pkg::FESC_CODE;
            else if (c == kfd_pkg::TFEND_CODE) c = kfd_pkg::FEND_CODE;
            esc_armed = 1'b0;
        end
        if (frame_len == 0) lead_byte = c;
        ev.kind = kfd_pkg::EVT_BYTE;
        ev.data_byte = c;
        ev.byte_index = kfd_pkg::IDX_W'(frame_len);
        frame_len++;
        idle_count = '0;
        expected_events.push_back(ev);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 34);
    end

    // The transfer happens at the next rising edge, since both sides hold their values.
    always @(negedge i_clk) begin
        kfd_pkg::t_kfd_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_events.size() == 0) begin
                $error("result transfer with no expected event: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", 16'(want.kind), 16'(m_axis_tuser));
                check_field("restarted", 16'(want.restarted), 16'(m_axis_tdata[0]));
                check_field("decoded_byte", 16'(want.data_byte), 16'(m_axis_tdata[8:1]));
                check_field("byte_index", 16'(want.byte_index), 16'(m_axis_tdata[17:9]));
                check_field("frame_length", 16'(want.frame_length), 16'(m_axis_tdata[26:18]));
                check_field("frame_class", 16'(want.frame_class), 16'(m_axis_tdata[29:27]));
                check_field("kiss_command", 16'(want.kiss_command), 16'(m_axis_tdata[33:30]));
                check_field("kiss_port", 16'(want.kiss_port), 16'(m_axis_tdata[37:34]));
                check_field("padding", 16'd0, 16'(m_axis_tdata[39:38]));
            end
        end
    end

    task automatic send_item(input kfd_pkg::t_item_kind kind, input logic [7:0] value);
        logic taken;
        if (!steady) begin
            while ($urandom_range(99) < 34) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end
        deframe_predict(kind, value);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(kfd_pkg::ITEM_TICK, 8'($urandom));
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        foreach (seq[i]) send_item(kfd_pkg::ITEM_BYTE, seq[i]);
    endtask

    task automatic send_run(input int n);
        logic [7:0] v;
        repeat (n) begin
            v = 8'($urandom);
            if (v == kfd_pkg::FEND_CODE || v == kfd_pkg::FESC_CODE) v = 8'h5A;
            send_item(kfd_pkg::ITEM_BYTE, v);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_idle_limit(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        idle_limit = value;
    endtask

    task automatic test_frame_classes();
        send_bytes('{kfd_pkg::FEND_CODE});
        send_bytes('{{4'h0, kfd_pkg::CMD_DATA}, 8'h41, 8'hFF, kfd_pkg::FEND_CODE});
        send_bytes('{kfd_pkg::RETURN_CODE, kfd_pkg::FEND_CODE});
        send_bytes('{8'h05, kfd_pkg::FEND_CODE});
        send_bytes('{8'hF0, 8'h00, kfd_pkg::FEND_CODE});
        send_bytes('{{4'h0, kfd_pkg::CMD_CFG_B}, 8'h00, kfd_pkg::FEND_CODE});
        send_bytes('{{4'h0, kfd_pkg::CMD_CFG_F}, 8'h01, kfd_pkg::FEND_CODE});
        send_bytes('{8'h07, 8'h80, kfd_pkg::FEND_CODE});
    endtask

    task automatic test_escapes();
        send_bytes('{{4'h0, kfd_pkg::CMD_CFG_D}, kfd_pkg::FESC_CODE, kfd_pkg::TFEND_CODE,
                     kfd_pkg::FESC_CODE, kfd_pkg::TFESC_CODE, kfd_pkg::FESC_CODE, 8'h7E,
                     kfd_pkg::FEND_CODE});
        send_bytes('{kfd_pkg::FESC_CODE, kfd_pkg::TFEND_CODE, kfd_pkg::FEND_CODE});
        send_bytes('{8'h00, 8'h01, kfd_pkg::FESC_CODE, kfd_pkg::FEND_CODE});
        send_bytes('{kfd_pkg::FESC_CODE, kfd_pkg::FEND_CODE, 8'hDC, kfd_pkg::FEND_CODE});
        send_bytes('{{4'h0, kfd_pkg::CMD_CFG_C}, kfd_pkg::FESC_CODE, kfd_pkg::FESC_CODE,
                     kfd_pkg::TFESC_CODE, kfd_pkg::FEND_CODE});
    endtask

    task automatic test_idle_timeout();
        wait_drained();
        write_idle_limit(16'd0);
        send_bytes('{8'h00});
        send_tick();
        send_bytes('{8'h11, 8'h22});
        send_tick();
        send_bytes('{kfd_pkg::FESC_CODE, 8'h33});
        send_tick();
        send_bytes('{kfd_pkg::FEND_CODE});
        wait_drained();
        write_idle_limit(16'd3);
        send_bytes('{8'h44});
        repeat (3) send_tick();
        send_bytes('{8'h55});
        repeat (4) send_tick();
        send_bytes('{8'h66, kfd_pkg::FEND_CODE});
    endtask

    task automatic test_overflow();
        wait_drained();
        write_idle_limit(kfd_pkg::TIMEOUT_RESET);
        send_run(509);
        send_bytes('{kfd_pkg::FEND_CODE});
        send_run(510);
        send_bytes('{kfd_pkg::FESC_CODE, kfd_pkg::TFEND_CODE, kfd_pkg::FEND_CODE});
    endtask

    task automatic send_random_burst();
        logic [7:0] lead;
        logic [3:0] cfg_cmds[4] = '{kfd_pkg::CMD_CFG_B, kfd_pkg::CMD_CFG_C,
                                    kfd_pkg::CMD_CFG_D, kfd_pkg::CMD_CFG_F};
        int         body;
        int         gap_max;
        gap_max = (idle_limit < 16'd20) ? int'(idle_limit) + 2 : 3;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(3) == 0) send_tick();
                else send_item(kfd_pkg::ITEM_BYTE, 8'($urandom));
            end
        end else begin
            case ($urandom_range(5))
                0: lead = kfd_pkg::RETURN_CODE;
                1: lead = {4'h0, kfd_pkg::CMD_DATA};
                2: lead = {4'h0, cfg_cmds[$urandom_range(3)]};
                3: lead = {4'h0, 4'($urandom)};
                default: lead = 8'($urandom);
            endcase
            if ($urandom_range(99) < 10) repeat ($urandom_range(0, gap_max)) send_tick();
            send_item(kfd_pkg::ITEM_BYTE, lead);
            body = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            repeat (body) begin
                if ($urandom_range(99) < 15) repeat ($urandom_range(0, gap_max)) send_tick();
                if ($urandom_range(99) < 15) begin
                    send_item(kfd_pkg::ITEM_BYTE, kfd_pkg::FESC_CODE);
                    case ($urandom_range(2))
                        0: send_item(kfd_pkg::ITEM_BYTE, kfd_pkg::TFEND_CODE);
                        1: send_item(kfd_pkg::ITEM_BYTE, kfd_pkg::TFESC_CODE);
                        default: send_item(kfd_pkg::ITEM_BYTE, 8'($urandom));
                    endcase
                end else begin
                    send_item(kfd_pkg::ITEM_BYTE, 8'($urandom));
                end
            end
            if ($urandom_range(99) < 6) send_item(kfd_pkg::ITEM_BYTE, kfd_pkg::FESC_CODE);
            send_item(kfd_pkg::ITEM_BYTE, kfd_pkg::FEND_CODE);
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] limits[$];
        int          start;
        limits = '{kfd_pkg::TIMEOUT_RESET, 16'd0, 16'd1, 16'd6, 16'd25, kfd_pkg::IDLE_MAX,
                   16'($urandom_range(2, 12))};
        start = items_sent;
        foreach (limits[p]) begin
            wait_drained();
            write_idle_limit(limits[p]);
            steady = (p == 0);
            while (items_sent - start < (p + 1) * 115) send_random_burst();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_frame_classes();
        test_escapes();
        test_idle_timeout();
        test_overflow();
        test_random_traffic();
        wait_drained();
        if (error_count == 0) begin
            $display("[kiss_frame_deframer] OK");
        end else begin
            $display("[kiss_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule
